// ===== hw/rtl/medr_pkg.sv =====
// shared constants, codes and controller/datapath types for the morse envelope run decoder
`default_nettype none
package medr_pkg;

  localparam int unsigned RUN_DEPTH = 32;
  localparam int unsigned RUN_AW    = $clog2(RUN_DEPTH);
  localparam int unsigned CNT_W     = $clog2(RUN_DEPTH + 1);
  localparam int unsigned MAX_GROUP = 4096;

  localparam int unsigned SMP_W  = 16;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned GRP_W  = 13;
  localparam int unsigned LVL_W  = 15;
  localparam int unsigned FILL_W = $clog2(MAX_GROUP + 1);
  localparam int unsigned SUM_W  = FILL_W + MAG_W - 1;
  localparam int unsigned LIM_W  = FILL_W + LVL_W;
  localparam int unsigned CMP_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned ENT_W  = LEN_W + 1;
  localparam int unsigned THR_W  = LEN_W + 2;
  localparam int unsigned SYM_W  = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL      = 2'd1;

  localparam logic [GRP_W-1:0] RESET_GROUP = 13'd882;
  localparam logic [LVL_W-1:0] RESET_LEVEL = 15'd50;

  localparam logic [SYM_W-1:0] SYM_DOT   = 2'd0;
  localparam logic [SYM_W-1:0] SYM_DASH  = 2'd1;
  localparam logic [SYM_W-1:0] SYM_SPACE = 2'd2;
  localparam logic [SYM_W-1:0] SYM_BREAK = 2'd3;

  typedef struct packed {
    logic acc;
    logic group;
    logic thr;
    logic rd;
    logic cls;
    logic shift;
    logic idx_next;
    logic flush;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic final_seen;
    logic no_runs;
    logic todo_any;
    logic can_shift;
    logic idx_last;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/medr_if.sv =====
// word channels: audio samples in, symbols out, register writes in
`default_nettype none
interface medr_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [medr_pkg::SMP_W-1:0] sample;
  logic                              final_req;
  modport source (output valid, sample, final_req, input ready);
  modport sink (input valid, sample, final_req, output ready);
endinterface

interface medr_symbol_if;
  logic                       valid;
  logic                       ready;
  logic [medr_pkg::SYM_W-1:0] symbol;
  logic                       last;
  logic                       overflow;
  modport source (output valid, symbol, last, overflow, input ready);
  modport sink (input valid, symbol, last, overflow, output ready);
endinterface

interface medr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [medr_pkg::CFG_IDX_W-1:0]  index;
  logic [medr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/medr_datapath.sv =====
// datapath: config registers, group accumulator, run tracking, run store and symbol output
`default_nettype none
module medr_datapath (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire signed [medr_pkg::SMP_W-1:0] smp_sample_i,
  input  wire                              smp_final_i,
  input  wire                              cfg_we_i,
  input  wire  [medr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [medr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  medr_pkg::cmd_t                   cmd_i,
  output medr_pkg::sts_t                   sts_o,
  input  wire                              out_ready_i,
  output logic                             out_valid_o,
  output logic [medr_pkg::SYM_W-1:0]       out_symbol_o,
  output logic                             out_last_o,
  output logic                             out_overflow_o
);

  logic [medr_pkg::GRP_W-1:0]  group_size_q;
  logic [medr_pkg::LVL_W-1:0]  level_q;
  logic [medr_pkg::FILL_W-1:0] gsz_eff;
  logic [medr_pkg::LIM_W-1:0]  limit_q;

  logic [medr_pkg::MAG_W-1:0]  mag;
  logic [medr_pkg::SUM_W-1:0]  sum_q;
  logic [medr_pkg::FILL_W-1:0] fill_q;
  logic [medr_pkg::FILL_W-1:0] fill_inc;
  logic                        grp_done_q;
  logic                        final_q;
  logic                        lvl;

  logic                                  cur_q;
  logic                                  first_q;
  logic [medr_pkg::LEN_W-1:0]            len_q;
  logic [medr_pkg::CNT_W-1:0]            count_q;
  logic [1:0][medr_pkg::LEN_W-1:0]       short_q;
  logic [1:0][medr_pkg::LEN_W-1:0]       long_q;
  logic                                  ovf_q;
  logic                                  close_run;
  logic                                  store_we;

  logic [medr_pkg::ENT_W-1:0] mem [medr_pkg::RUN_DEPTH];
  logic [medr_pkg::ENT_W-1:0] rdata_q;

  logic signed [medr_pkg::THR_W-1:0] lg_q;
  logic signed [medr_pkg::THR_W-1:0] wg_q;
  logic [medr_pkg::LEN_W-1:0]        dash_q;
  logic [medr_pkg::LEN_W:0]          on_sum;
  logic [medr_pkg::RUN_AW-1:0]       idx_q;
  logic [medr_pkg::LEN_W-1:0]        rd_len;
  logic signed [medr_pkg::THR_W-1:0] rd_len_s;

  logic [1:0]                 todo_q;
  logic [medr_pkg::SYM_W-1:0] sym_a_q;
  logic [medr_pkg::SYM_W-1:0] pick;
  logic                       pend_valid_q;
  logic [medr_pkg::SYM_W-1:0] pend_sym_q;
  logic                       out_valid_q;
  logic                       out_free;
  logic                       push;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= medr_pkg::RESET_GROUP;
      level_q      <= medr_pkg::RESET_LEVEL;
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == medr_pkg::CFG_GROUP_SIZE) begin
        group_size_q <= cfg_data_i[medr_pkg::GRP_W-1:0];
      end else if (cfg_index_i == medr_pkg::CFG_LEVEL) begin
        level_q <= cfg_data_i[medr_pkg::LVL_W-1:0];
      end else begin
        group_size_q <= group_size_q;
      end
    end
  end

  always_comb begin
    if (group_size_q == '0) begin
      gsz_eff = medr_pkg::FILL_W'(1);
    end else if (32'(group_size_q) > medr_pkg::MAX_GROUP) begin
      gsz_eff = medr_pkg::FILL_W'(medr_pkg::MAX_GROUP);
    end else begin
      gsz_eff = medr_pkg::FILL_W'(group_size_q);
    end
  end

  // threshold product, registered every cycle
  always_ff @(posedge clk_i) begin
    limit_q <= medr_pkg::LIM_W'(gsz_eff) * medr_pkg::LIM_W'(level_q);
  end

  assign mag      = smp_sample_i[medr_pkg::SMP_W-1] ? medr_pkg::MAG_W'(-smp_sample_i)
                                                    : medr_pkg::MAG_W'(smp_sample_i);
  assign fill_inc = fill_q + medr_pkg::FILL_W'(1);
  assign lvl      = medr_pkg::CMP_W'(sum_q) > medr_pkg::CMP_W'(limit_q);

  assign close_run = cmd_i.group && grp_done_q && first_q && (lvl != cur_q);
  assign store_we  = close_run && (count_q < medr_pkg::CNT_W'(medr_pkg::RUN_DEPTH));

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      fill_q     <= '0;
      grp_done_q <= 1'b0;
      final_q    <= 1'b0;
      cur_q      <= 1'b0;
      first_q    <= 1'b0;
      len_q      <= '0;
      count_q    <= '0;
      short_q    <= '1;
      long_q     <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.clear) begin
      sum_q      <= '0;
      fill_q     <= '0;
      grp_done_q <= 1'b0;
      final_q    <= 1'b0;
      cur_q      <= 1'b0;
      first_q    <= 1'b0;
      len_q      <= '0;
      count_q    <= '0;
      short_q    <= '1;
      long_q     <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.acc) begin
      sum_q      <= sum_q + medr_pkg::SUM_W'(mag);
      fill_q     <= fill_inc;
      grp_done_q <= fill_inc >= gsz_eff;
      final_q    <= smp_final_i;
    end else if (cmd_i.group && grp_done_q) begin
      sum_q  <= '0;
      fill_q <= '0;
      if (!first_q) begin
        first_q <= 1'b1;
        cur_q   <= lvl;
        len_q   <= medr_pkg::LEN_W'(1);
      end else if (lvl == cur_q) begin
        if (len_q != '1) begin
          len_q <= len_q + medr_pkg::LEN_W'(1);
        end
      end else begin
        if (len_q > long_q[cur_q]) begin
          long_q[cur_q] <= len_q;
        end
        if (len_q < short_q[cur_q]) begin
          short_q[cur_q] <= len_q;
        end
        if (store_we) begin
          count_q <= count_q + medr_pkg::CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
        cur_q <= lvl;
        len_q <= medr_pkg::LEN_W'(1);
      end
    end
  end

  // run store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem[count_q[medr_pkg::RUN_AW-1:0]] <= {cur_q, len_q};
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  // replay thresholds
  assign on_sum = {1'b0, short_q[1]} + {1'b0, long_q[1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.thr) begin
      lg_q   <= $signed({1'b0, short_q[0], 1'b0}) - medr_pkg::THR_W'(1);
      wg_q   <= $signed({2'b00, long_q[0]}) - $signed({2'b00, short_q[0]});
      dash_q <= on_sum[medr_pkg::LEN_W:1];
    end
  end

  assign rd_len   = rdata_q[medr_pkg::LEN_W-1:0];
  assign rd_len_s = $signed({2'b00, rd_len});
  assign pick     = todo_q[0] ? sym_a_q : medr_pkg::SYM_BREAK;
  assign out_free = !out_valid_q || out_ready_i;
  assign push     = (cmd_i.shift || cmd_i.flush) && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      todo_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.thr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_next) begin
        idx_q <= idx_q + medr_pkg::RUN_AW'(1);
      end
      if (cmd_i.cls) begin
        if (rdata_q[medr_pkg::LEN_W]) begin
          todo_q <= 2'b01;
        end else begin
          todo_q <= {rd_len_s > wg_q, rd_len_s > lg_q};
        end
      end else if (cmd_i.shift) begin
        todo_q <= todo_q[0] ? {todo_q[1], 1'b0} : 2'b00;
      end
      if (cmd_i.shift) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cls) begin
      if (rdata_q[medr_pkg::LEN_W]) begin
        sym_a_q <= (rd_len > dash_q) ? medr_pkg::SYM_DASH : medr_pkg::SYM_DOT;
      end else begin
        sym_a_q <= medr_pkg::SYM_SPACE;
      end
    end
    if (cmd_i.shift) begin
      pend_sym_q <= pick;
    end
    if (push) begin
      out_symbol_o   <= pend_sym_q;
      out_last_o     <= cmd_i.flush;
      out_overflow_o <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.final_seen = final_q;
    sts_o.no_runs    = (count_q == '0);
    sts_o.todo_any   = |todo_q;
    sts_o.can_shift  = !pend_valid_q || out_free;
    sts_o.idx_last   = (medr_pkg::CNT_W'(idx_q) + medr_pkg::CNT_W'(1)) == count_q;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= medr_pkg::CNT_W'(medr_pkg::RUN_DEPTH))
    else $error("run count beyond store depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == medr_pkg::CNT_W'(medr_pkg::RUN_DEPTH))
    else $error("overflow flagged with room left in store");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (long_q[0] == '0 || short_q[0] <= long_q[0]) &&
    (long_q[1] == '0 || short_q[1] <= long_q[1]))
    else $error("shortest run above longest run");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> len_q != '0)
    else $error("open run has zero length");

endmodule
`default_nettype wire

// ===== hw/rtl/medr_ctrl.sv =====
// controller state machine: sample intake, group update, threshold setup and run replay
`default_nettype none
module medr_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  medr_pkg::sts_t  sts_i,
  output medr_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GROUP = 3'd1;
  localparam logic [2:0] S_THR   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CLS   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          state_d   = S_GROUP;
        end
      end
      S_GROUP: begin
        cmd_o.group = 1'b1;
        state_d     = sts_i.final_seen ? S_THR : S_IDLE;
      end
      S_THR: begin
        cmd_o.thr = 1'b1;
        state_d   = sts_i.no_runs ? S_CLEAR : S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CLS;
      end
      S_CLS: begin
        cmd_o.cls = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.todo_any) begin
          if (sts_i.idx_last) begin
            state_d = S_FLUSH;
          end else begin
            cmd_o.idx_next = 1'b1;
            state_d        = S_RD;
          end
        end else if (sts_i.can_shift) begin
          cmd_o.shift = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = S_CLEAR;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/morse_envelope_run_decoder_core.sv =====
// Morse envelope run decoder top level. Each accepted audio sample takes two steps:
// the first adds its magnitude into the group sum, the second, once the group is
// complete, compares it with group_size*level and updates the run tracker and its
// 32-entry run store. The sample marked final_req then starts a replay: a threshold
// step, then per stored run a store read, a classify step and an emit step that
// sends one symbol per cycle while the output can take them; a flush step sends the
// held last symbol and a clear step resets the stream state. No sample is taken
// during the replay. A held-symbol register lets replay run ahead by one symbol
// while the sink stalls. Register writes are meant for idle time only.
`default_nettype none
module morse_envelope_run_decoder_core (
  input wire             clk_i,
  input wire             rst_ni,
  medr_sample_if.sink    smp_i,
  medr_symbol_if.source  sym_o,
  medr_cfg_if.sink       cfg_i
);

  medr_pkg::cmd_t cmd;
  medr_pkg::sts_t sts;
  logic           in_ready;
  logic           cfg_we;

  assign smp_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  medr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  medr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .smp_sample_i   (smp_i.sample),
    .smp_final_i    (smp_i.final_req),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (sym_o.ready),
    .out_valid_o    (sym_o.valid),
    .out_symbol_o   (sym_o.symbol),
    .out_last_o     (sym_o.last),
    .out_overflow_o (sym_o.overflow)
  );

endmodule
`default_nettype wire
